[src/rlsu_pkg.sv]
// Package for the run-length to pixel segment unit: constants, types, helper functions.
package rlsu_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int DIM_W         = $clog2(MAX_DIMENSION) + 1;
  localparam int COORD_W       = $clog2(MAX_DIMENSION);
  localparam int SEG_LIMIT     = 64;
  localparam int SEG_CNT_W     = $clog2(SEG_LIMIT);
  localparam int MIN_WIDTH     = 4;
  localparam int CHUNK_MAX     = 5;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic [2:0] CH_GRAY = 3'd1;
  localparam logic [2:0] CH_RGB  = 3'd3;
  localparam logic [2:0] CH_RGBA = 3'd4;

  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd2;

  localparam logic [2:0]  RST_CHANNEL_COUNT = 3'd3;
  localparam logic [12:0] RST_IMAGE_WIDTH   = 13'd800;
  localparam logic [12:0] RST_IMAGE_HEIGHT  = 13'd600;

  typedef struct packed {
    logic ingest;
    logic start;
    logic calc_len;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic go_run;
    logic wrap_end;
    logic out_free;
    logic seg_last;
  } status_t;

  function automatic logic [DIM_W-1:0] eff_width(input logic [12:0] w);
    logic [DIM_W-1:0] r;
    if (w < 13'(MIN_WIDTH)) r = DIM_W'(MIN_WIDTH);
    else if (w > 13'(MAX_DIMENSION)) r = DIM_W'(MAX_DIMENSION);
    else r = DIM_W'(w);
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] eff_height(input logic [12:0] h);
    logic [DIM_W-1:0] r;
    if (h > 13'(MAX_DIMENSION)) r = DIM_W'(MAX_DIMENSION);
    else r = DIM_W'(h);
    return r;
  endfunction

  function automatic logic [2:0] chunk_len(input logic [2:0] cc);
    logic [2:0] r;
    if (cc >= 3'(CHUNK_MAX - 1)) r = 3'(CHUNK_MAX);
    else r = cc + 3'd1;
    return r;
  endfunction

  function automatic logic [31:0] make_color(input logic [2:0] cc, input logic [31:0] cb);
    logic [31:0] r;
    case (cc)
      CH_RGB:  r = {ALPHA_OPAQUE, cb[7:0], cb[15:8], cb[23:16]};
      CH_RGBA: r = {cb[31:24], cb[7:0], cb[15:8], cb[23:16]};
      CH_GRAY: r = {ALPHA_OPAQUE, cb[7:0], cb[7:0], cb[7:0]};
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

[src/rlsu_ctrl.sv]
// Controller state machine: byte intake, run start, segment length and emit sequencing.
module rlsu_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rlsu_pkg::status_t status,
  output rlsu_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRAP,
    S_LEN,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ingest = 1'b1;
          if (status.go_run) state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        cmd.start = 1'b1;
        state_nxt = status.wrap_end ? S_IDLE : S_LEN;
      end
      S_LEN: begin
        cmd.calc_len = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = status.seg_last ? S_IDLE : S_LEN;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/rlsu_dpath.sv]
// Datapath: configuration, chunk gathering, cursor, segment arithmetic and output register.
module rlsu_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [12:0]       cfg_data,
  input  logic [7:0]        in_byte,
  input  logic              out_ready,
  input  rlsu_pkg::cmd_t    cmd,
  output rlsu_pkg::status_t status,
  output logic              out_valid,
  output logic [63:0]       out_data,
  output logic              out_last,
  output logic              out_frame
);

  localparam int DW = rlsu_pkg::DIM_W;
  localparam int CW = rlsu_pkg::COORD_W;
  localparam int NW = rlsu_pkg::SEG_CNT_W;

  logic [2:0]    cc_r;
  logic [12:0]   width_r, height_r;
  logic [2:0]    bp_r;
  logic [7:0]    run_r;
  logic [31:0]   cbytes_r;
  logic [CW-1:0] col_r;
  logic [DW-1:0] row_r;
  logic          done_r;
  logic [7:0]    rem_r, len_r;
  logic [NW-1:0] nseg_r;
  logic [31:0]   color_r;

  logic          ovalid_r, olast_r, oframe_r;
  logic [CW-1:0] orow_r, ocol_r;
  logic [7:0]    olen_r;
  logic [31:0]   ocolor_r;

  logic [DW-1:0] w, h, row_inc, left, col_sum;
  logic [2:0]    bp_inc;
  logic          blocked, chunk_end, wrap, fin;
  logic [7:0]    run_new, rem_left;

  always_comb begin
    w         = rlsu_pkg::eff_width(width_r);
    h         = rlsu_pkg::eff_height(height_r);
    bp_inc    = bp_r + 3'd1;
    chunk_end = bp_inc >= rlsu_pkg::chunk_len(cc_r);
    blocked   = done_r || (row_r >= h);
    run_new   = (bp_r == 3'd0) ? in_byte : run_r;
    row_inc   = row_r + DW'(1);
    left      = w - DW'(col_r);
    col_sum   = DW'(col_r) + DW'(len_r);
    wrap      = col_sum >= w;
    fin       = wrap && (row_inc >= h);
    rem_left  = rem_r - len_r;

    status.go_run   = !blocked && chunk_end && (run_new != 8'd0);
    status.wrap_end = (DW'(col_r) >= w) && (row_inc >= h);
    status.out_free = !ovalid_r || out_ready;
    status.seg_last = (rem_left == 8'd0) || fin || (nseg_r == NW'(rlsu_pkg::SEG_LIMIT - 1));
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r     <= rlsu_pkg::RST_CHANNEL_COUNT;
      width_r  <= rlsu_pkg::RST_IMAGE_WIDTH;
      height_r <= rlsu_pkg::RST_IMAGE_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        rlsu_pkg::REG_CHANNEL_COUNT: cc_r     <= cfg_data[2:0];
        rlsu_pkg::REG_IMAGE_WIDTH:   width_r  <= cfg_data;
        rlsu_pkg::REG_IMAGE_HEIGHT:  height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // chunk gathering and cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r     <= 3'd0;
      run_r    <= 8'd0;
      cbytes_r <= 32'd0;
      col_r    <= '0;
      row_r    <= '0;
      done_r   <= 1'b0;
    end else begin
      if (cmd.ingest) begin
        if (blocked) begin
          done_r <= 1'b1;
        end else begin
          case (bp_r)
            3'd0:    run_r           <= in_byte;
            3'd1:    cbytes_r[7:0]   <= in_byte;
            3'd2:    cbytes_r[15:8]  <= in_byte;
            3'd3:    cbytes_r[23:16] <= in_byte;
            3'd4:    cbytes_r[31:24] <= in_byte;
            default: ;
          endcase
          bp_r <= chunk_end ? 3'd0 : bp_inc;
        end
      end
      if (cmd.start && (DW'(col_r) >= w)) begin
        col_r <= '0;
        row_r <= row_inc;
        if (row_inc >= h) done_r <= 1'b1;
      end
      if (cmd.emit) begin
        if (wrap) begin
          col_r <= '0;
          row_r <= row_inc;
        end else begin
          col_r <= col_sum[CW-1:0];
        end
        if (fin) done_r <= 1'b1;
      end
    end
  end

  // per-run working registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r   <= run_r;
      nseg_r  <= '0;
      color_r <= rlsu_pkg::make_color(cc_r, cbytes_r);
    end
    if (cmd.calc_len) begin
      len_r <= (DW'(rem_r) < left) ? rem_r : left[7:0];
    end
    if (cmd.emit) begin
      rem_r  <= rem_left;
      nseg_r <= nseg_r + NW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.emit) begin
      ovalid_r <= 1'b1;
    end else if (out_ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      orow_r   <= row_r[CW-1:0];
      ocol_r   <= col_r;
      olen_r   <= len_r;
      ocolor_r <= color_r;
      olast_r  <= status.seg_last;
      oframe_r <= fin;
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = {ocolor_r, olen_r, ocol_r, orow_r};
  assign out_last  = olast_r;
  assign out_frame = oframe_r;

endmodule

[src/rle_run_to_pixel_segments_unit.sv]
// Top level of the run-length to pixel segment unit.
//
//  channel | dir    | tdata / data                                    | sideband
//  in_     | slave  | [7:0] stream_byte                               | -
//  out_    | master | [11:0] row [23:12] col [31:24] len [63:32] argb | tlast, tuser[0] done
//  cfg_    | write  | index 0 chan, 1 width, 2 height                 | cfg_data [12:0]
//
// A byte is taken in the idle state; a byte that completes a chunk with a non-zero
// run while the frame is not done adds a row wrap check and, per emitted segment,
// a length and an emit state. Segment rate is set by the controller's length/emit sequence.
// A held output stalls the emit step and the input with it; after the last
// segment of a run, bytes are taken while that segment waits.
// Reset is synchronous (rst_n low); no clearing pass. Config port always ready.
module rle_run_to_pixel_segments_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] stream_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // seg_row, seg_column, seg_length, seg_color
  output logic        out_tlast,
  output logic [0:0]  out_tuser,  // [0] frame_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  rlsu_pkg::cmd_t    cmd;
  rlsu_pkg::status_t status;
  logic              frame;

  assign cfg_ready    = 1'b1;
  assign out_tuser[0] = frame;

  rlsu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rlsu_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (in_tdata),
    .out_ready (out_tready),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_last  (out_tlast),
    .out_frame (frame)
  );

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid || out_tready))
    else $error("segment emitted over an untaken transaction");

  a_no_intake_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !in_tready)
    else $error("byte intake open during segment emission");

  a_frame_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tlast)
    else $error("frame end not marked as last segment of run");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_tvalid)
    else $error("emitted segment not presented");

endmodule
